[design/polygon_perimeter_weighted_center_top_assert.svh]
// Assertion macros for the polygon perimeter weighted center block.
`ifndef POLYGON_PERIMETER_WEIGHTED_CENTER_TOP_ASSERT_SVH
`define POLYGON_PERIMETER_WEIGHTED_CENTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PPWC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ppwc assertion failed");
// Next-cycle implication.
`define PPWC_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ppwc assertion failed");
`else
`define PPWC_ASSERT_IMP(label, clk, rst, pre, post)
`define PPWC_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

[design/ppwc_pkg.sv]
// Shared types and constants for the polygon perimeter weighted center block.
`default_nettype none
package ppwc_pkg;
   localparam int COORD_W = 32;
   localparam int TAG_W   = 16;
   localparam int RAD_W   = 66;
   localparam int ROOT_W  = 34;
   localparam int PERIM_W = 48;
   localparam int WSUM_W  = 64;

   // One queued corner, with the front's classification of face start.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               last;
      logic [TAG_W-1:0]   tag;
      logic               first;
   } item_type;

   // Queue status seen by the back end and the top level.
   typedef struct packed {
      logic valid;
      logic full;
   } qstat_type;
endpackage
`default_nettype wire

[design/ppwc_front.sv]
// Front end: accepts corners, marks face starts and queues them.
`default_nettype none
module ppwc_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [ppwc_pkg::COORD_W-1:0] req_point_x,
   input  wire logic [ppwc_pkg::COORD_W-1:0] req_point_y,
   input  wire logic [ppwc_pkg::COORD_W-1:0] req_point_z,
   input  wire logic                        req_last_point,
   input  wire logic [ppwc_pkg::TAG_W-1:0]   req_face_tag,
   output ppwc_pkg::qstat_type              q_stat,
   output ppwc_pkg::item_type               q_item,
   input  wire logic                        q_pop
);
   import ppwc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       face_start_ff;
   logic       push;
   logic       pop;

   assign req_stall    = (count_ff == 2'd2);
   assign push         = req_valid && !req_stall;
   assign pop          = q_pop && (count_ff != 2'd0);
   assign q_stat.valid = (count_ff != 2'd0);
   assign q_stat.full  = req_stall;
   assign q_item       = slot_ff[rd_ptr_ff];

   // Queue pointers, occupancy and the face start marker.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= 2'd0;
         face_start_ff <= 1'b1;
      end else begin
         if (push) begin
            wr_ptr_ff     <= ~wr_ptr_ff;
            face_start_ff <= req_last_point;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{x: req_point_x, y: req_point_y, z: req_point_z,
                                 last: req_last_point, tag: req_face_tag,
                                 first: face_start_ff};
      end
   end
endmodule
`default_nettype wire

[design/ppwc_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module ppwc_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ppwc_pkg::RAD_W-1:0]  radicand,
   output logic                            done,
   output logic [ppwc_pkg::ROOT_W-1:0]      root
);
   import ppwc_pkg::*;

   logic [67:0]       rad_ff;
   logic [35:0]       rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [37:0]       rem_sh;
   logic [37:0]       trial;
   logic              fits;
   logic [35:0]       rem_next;

   // One restoring step of the digit-by-digit root.
   always_comb begin
      rem_sh   = {rem_ff, rad_ff[67:66]};
      trial    = {2'b00, root_ff, 2'b01};
      fits     = (rem_sh >= trial);
      rem_next = fits ? 36'(rem_sh - trial) : rem_sh[35:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'(ROOT_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {2'b00, radicand};
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[65:0], 2'b00};
         rem_ff  <= rem_next;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
         cnt_ff  <= cnt_ff + 6'd1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

[design/ppwc_div.sv]
// Iterative saturating divider: (weighted sum * 2^16) / perimeter, one bit per cycle.
`default_nettype none
module ppwc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ppwc_pkg::WSUM_W-1:0]  dividend,
   input  wire logic [ppwc_pkg::PERIM_W-1:0] divisor,
   output logic                             done,
   output logic [ppwc_pkg::COORD_W-1:0]      quotient
);
   import ppwc_pkg::*;

   localparam int DVD_W = WSUM_W + 16;
   localparam logic [33:0] CAP     = 34'h1_0000_0000;
   localparam logic [32:0] POS_MAX = 33'h0_7FFF_FFFF;
   localparam logic [32:0] NEG_MAX = 33'h0_8000_0000;

   logic [DVD_W-1:0]   dvd_ff;
   logic [PERIM_W-1:0] rem_ff;
   logic [PERIM_W-1:0] p_ff;
   logic [32:0]        q_ff;
   logic               neg_ff;
   logic [6:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [COORD_W-1:0] res_ff;
   logic [WSUM_W-1:0]  mag;
   logic [PERIM_W:0]   rem_sh;
   logic               fits;
   logic [PERIM_W-1:0] rem_next;
   logic [33:0]        q_sh;
   logic [32:0]        q_next;
   logic [32:0]        q_neg;
   logic [COORD_W-1:0] res_next;

   assign mag = dividend[WSUM_W-1] ? (~dividend + 64'd1) : dividend;

   // One restoring step, with the quotient held at its cap.
   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
      fits     = (rem_sh >= {1'b0, p_ff});
      rem_next = fits ? PERIM_W'(rem_sh - {1'b0, p_ff}) : rem_sh[PERIM_W-1:0];
      q_sh     = {q_ff, fits};
      q_next   = (q_sh > CAP) ? CAP[32:0] : q_sh[32:0];
      q_neg    = (q_next > NEG_MAX) ? NEG_MAX : q_next;
      if (neg_ff) begin
         res_next = 32'(~q_neg + 33'd1);
      end else begin
         res_next = (q_next > POS_MAX) ? POS_MAX[31:0] : q_next[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 7'(DVD_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {mag, 16'h0000};
         rem_ff <= '0;
         p_ff   <= divisor;
         q_ff   <= '0;
         neg_ff <= dividend[WSUM_W-1];
         cnt_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= rem_next;
         q_ff   <= q_next;
         cnt_ff <= cnt_ff + 7'd1;
         if (cnt_ff == 7'(DVD_W - 1)) begin
            res_ff <= res_next;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = res_ff;
endmodule
`default_nettype wire

[design/ppwc_back.sv]
// Back end: edge lengths, weighted sums, center division and the result register.
`default_nettype none
module ppwc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  ppwc_pkg::qstat_type              q_stat,
   input  ppwc_pkg::item_type               q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [ppwc_pkg::COORD_W-1:0]      rsp_center_x,
   output logic [ppwc_pkg::COORD_W-1:0]      rsp_center_y,
   output logic [ppwc_pkg::COORD_W-1:0]      rsp_center_z,
   output logic                             rsp_degenerate,
   output logic [ppwc_pkg::TAG_W-1:0]        rsp_result_tag
);
   import ppwc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQ     = 3'd1;
   localparam logic [2:0] S_ROOT   = 3'd2;
   localparam logic [2:0] S_WT     = 3'd3;
   localparam logic [2:0] S_DSTART = 3'd4;
   localparam logic [2:0] S_DWAIT  = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [2:0]         state_ff;
   item_type           cur_ff;
   logic [COORD_W-1:0] first_ff [3];
   logic [COORD_W-1:0] prev_ff  [3];
   logic [COORD_W-1:0] ea_ff    [3];
   logic [COORD_W-1:0] eb_ff    [3];
   logic               closing_ff;
   logic [1:0]         cnt_ff;
   logic [RAD_W-1:0]   sum_ff;
   logic [66:0]        mul_ff;
   logic               sgn_ff;
   logic [ROOT_W-1:0]  len_ff;
   logic [PERIM_W-1:0] perim_ff;
   logic [WSUM_W-1:0]  wsum_ff  [3];
   logic [COORD_W-1:0] cen_ff   [3];
   logic               degen_ff;
   logic [1:0]         axis_ff;
   logic               rsp_valid_ff;
   logic [COORD_W-1:0] rsp_x_ff;
   logic [COORD_W-1:0] rsp_y_ff;
   logic [COORD_W-1:0] rsp_z_ff;
   logic               rsp_deg_ff;
   logic [TAG_W-1:0]   rsp_tag_ff;

   logic [1:0]         kidx;
   logic [1:0]         widx;
   logic [32:0]        diff;
   logic [32:0]        diff_mag;
   logic [32:0]        sum_ab;
   logic [32:0]        sum_mag;
   logic [ROOT_W-1:0]  mul_a;
   logic [32:0]        mul_b;
   logic [RAD_W-1:0]   sum_next;
   logic [49:0]        term;
   logic [WSUM_W:0]    sterm;
   logic [WSUM_W:0]    acc;
   logic [WSUM_W-1:0]  acc_sat;
   logic [PERIM_W:0]   perim_add;
   logic               out_free;
   logic               sq_start;
   logic               sq_done;
   logic [ROOT_W-1:0]  sq_root;
   logic               dv_start;
   logic               dv_done;
   logic [COORD_W-1:0] dv_quot;
   logic [COORD_W-1:0] pt [3];

   assign pt[0] = q_item.x;
   assign pt[1] = q_item.y;
   assign pt[2] = q_item.z;

   assign q_pop    = (state_ff == S_IDLE) && q_stat.valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sq_start = (state_ff == S_SQ) && (cnt_ff == 2'd3);
   assign dv_start = (state_ff == S_DSTART);

   // Operand selection for the shared multiplier and the accumulators.
   always_comb begin
      kidx     = (cnt_ff == 2'd3) ? 2'd0 : cnt_ff;
      widx     = cnt_ff - 2'd1;
      diff     = {ea_ff[kidx][31], ea_ff[kidx]} - {eb_ff[kidx][31], eb_ff[kidx]};
      diff_mag = diff[32] ? (~diff + 33'd1) : diff;
      sum_ab   = {ea_ff[kidx][31], ea_ff[kidx]} + {eb_ff[kidx][31], eb_ff[kidx]};
      sum_mag  = sum_ab[32] ? (~sum_ab + 33'd1) : sum_ab;
      mul_a    = (state_ff == S_WT) ? len_ff : {1'b0, diff_mag};
      mul_b    = (state_ff == S_WT) ? sum_mag : diff_mag;
      sum_next = sum_ff + mul_ff[RAD_W-1:0];
      term     = mul_ff[66:17];
      sterm    = sgn_ff ? (~{15'd0, term} + 65'd1) : {15'd0, term};
      acc      = {wsum_ff[widx][WSUM_W-1], wsum_ff[widx]} + sterm;
      if (acc[WSUM_W] != acc[WSUM_W-1]) begin
         acc_sat = acc[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
      end else begin
         acc_sat = acc[WSUM_W-1:0];
      end
      perim_add = {1'b0, perim_ff} + {{(PERIM_W-ROOT_W+1){1'b0}}, sq_root};
   end

   // Shared multiplier, registered.
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      sgn_ff <= sum_ab[32];
   end

   ppwc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_next),
      .done     (sq_done),
      .root     (sq_root)
   );

   ppwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (wsum_ff[axis_ff]),
      .divisor  (perim_ff),
      .done     (dv_done),
      .quotient (dv_quot)
   );

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  if (q_item.first) begin
                     state_ff <= q_item.last ? S_EMIT : S_IDLE;
                  end else begin
                     state_ff <= S_SQ;
                  end
               end
            end
            S_SQ: begin
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (sq_done) begin
                  state_ff <= S_WT;
               end
            end
            S_WT: begin
               if (cnt_ff == 2'd3) begin
                  if (!closing_ff) begin
                     state_ff <= cur_ff.last ? S_SQ : S_IDLE;
                  end else begin
                     state_ff <= (perim_ff == '0) ? S_EMIT : S_DSTART;
                  end
               end
            end
            S_DSTART: state_ff <= S_DWAIT;
            S_DWAIT: begin
               if (dv_done) begin
                  state_ff <= (axis_ff == 2'd2) ? S_EMIT : S_DSTART;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Accumulators; they return to zero after each emitted face.
   always_ff @(posedge clock) begin
      if (reset) begin
         perim_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            wsum_ff[k]  <= '0;
            first_ff[k] <= '0;
            prev_ff[k]  <= '0;
         end
      end else begin
         if (state_ff == S_ROOT && sq_done) begin
            perim_ff <= perim_add[PERIM_W] ? {PERIM_W{1'b1}} : perim_add[PERIM_W-1:0];
         end
         if (state_ff == S_WT && cnt_ff != 2'd0) begin
            wsum_ff[widx] <= acc_sat;
         end
         if (state_ff == S_EMIT && out_free) begin
            perim_ff <= '0;
            for (int k = 0; k < 3; k++) begin
               wsum_ff[k] <= '0;
            end
         end
         if (q_pop) begin
            for (int k = 0; k < 3; k++) begin
               prev_ff[k] <= pt[k];
               if (q_item.first) begin
                  first_ff[k] <= pt[k];
               end
            end
         end
      end
   end

   // Edge operands, step counters and the center registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff     <= q_item;
         closing_ff <= 1'b0;
         cnt_ff     <= 2'd0;
         sum_ff     <= '0;
         for (int k = 0; k < 3; k++) begin
            ea_ff[k]  <= prev_ff[k];
            eb_ff[k]  <= pt[k];
            cen_ff[k] <= '0;
         end
         degen_ff <= 1'b1;
      end
      if (state_ff == S_SQ) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff != 2'd0) begin
            sum_ff <= sum_next;
         end
      end
      if (state_ff == S_ROOT && sq_done) begin
         len_ff <= sq_root;
         cnt_ff <= 2'd0;
      end
      if (state_ff == S_WT) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            axis_ff <= 2'd0;
            if (!closing_ff) begin
               closing_ff <= 1'b1;
               sum_ff     <= '0;
               for (int k = 0; k < 3; k++) begin
                  ea_ff[k] <= first_ff[k];
                  eb_ff[k] <= prev_ff[k];
               end
            end
         end
      end
      if (state_ff == S_DWAIT && dv_done) begin
         cen_ff[axis_ff] <= dv_quot;
         axis_ff         <= axis_ff + 2'd1;
         if (axis_ff == 2'd2) begin
            degen_ff <= 1'b0;
         end
      end
   end

   // Result register; it holds until the transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EMIT && out_free) begin
         rsp_x_ff   <= cen_ff[0];
         rsp_y_ff   <= cen_ff[1];
         rsp_z_ff   <= cen_ff[2];
         rsp_deg_ff <= degen_ff;
         rsp_tag_ff <= cur_ff.tag;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_center_x   = rsp_x_ff;
   assign rsp_center_y   = rsp_y_ff;
   assign rsp_center_z   = rsp_z_ff;
   assign rsp_degenerate = rsp_deg_ff;
   assign rsp_result_tag = rsp_tag_ff;
endmodule
`default_nettype wire

[design/polygon_perimeter_weighted_center_top.sv]
// Top level of the polygon perimeter weighted center block.
//
// Corners of a face enter one per transfer on the req_ channel and wait in a
// two-entry queue; the back end handles one corner at a time. A corner that
// closes an edge takes three squarings on the shared multiplier, the
// bit-serial square root, and three weighting products. The last corner of a
// face adds the closing edge and then, if the perimeter is nonzero, three
// divisions on the serial divider before the face result appears. A face's
// first corner only records its start point and opens no edge. The result
// waits in an output register, and the queue keeps taking corners while it
// waits.
`default_nettype none
module polygon_perimeter_weighted_center_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [ppwc_pkg::COORD_W-1:0] req_point_x,
   input  wire logic [ppwc_pkg::COORD_W-1:0] req_point_y,
   input  wire logic [ppwc_pkg::COORD_W-1:0] req_point_z,
   input  wire logic                        req_last_point,
   input  wire logic [ppwc_pkg::TAG_W-1:0]   req_face_tag,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [ppwc_pkg::COORD_W-1:0]      rsp_center_x,
   output logic [ppwc_pkg::COORD_W-1:0]      rsp_center_y,
   output logic [ppwc_pkg::COORD_W-1:0]      rsp_center_z,
   output logic                             rsp_degenerate,
   output logic [ppwc_pkg::TAG_W-1:0]        rsp_result_tag
);
   import ppwc_pkg::*;
`include "polygon_perimeter_weighted_center_top_assert.svh"

   qstat_type q_stat;
   item_type  q_item;
   logic      q_pop;
   logic      cen_zero;

   ppwc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_last_point (req_last_point),
      .req_face_tag   (req_face_tag),
      .q_stat         (q_stat),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   ppwc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_center_x   (rsp_center_x),
      .rsp_center_y   (rsp_center_y),
      .rsp_center_z   (rsp_center_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_result_tag (rsp_result_tag)
   );

   assign cen_zero = (rsp_center_x == '0) && (rsp_center_y == '0) && (rsp_center_z == '0);

   // A degenerate face always reports a zero center.
   `PPWC_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, cen_zero)
   // The back end only pops a nonempty queue, and a full queue holds items.
   `PPWC_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop || q_stat.full, q_stat.valid)
   // No result is shown right after reset.
   `PPWC_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)
endmodule
`default_nettype wire
